FILE: src/sample_player_interp_loop_unit_defines.svh
// Assertion macros for the sample player with interpolation and loop folding.
`ifndef SAMPLE_PLAYER_INTERP_LOOP_UNIT_DEFINES_SVH
`define SAMPLE_PLAYER_INTERP_LOOP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPIL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPIL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/spil_pkg.sv
// Package with widths, codes and state encoding of the sample player.
package spil_pkg;

	localparam int CFG_W                = 32;
	localparam int CFG_IDX_W            = 2;
	localparam int SAMPLE_W             = 16;
	localparam int PHASE_W              = 32;
	localparam int FRAC_BITS            = 16;
	localparam int POS_W                = PHASE_W - FRAC_BITS;
	localparam int COUNT_W              = 17;
	localparam int AMP_W                = 32;
	localparam int ACC_W                = 32;
	localparam int PROD_W               = AMP_W + SAMPLE_W;
	localparam int DIV_STEPS            = 32;
	localparam int DIV_CNT_W            = $clog2(DIV_STEPS);
	localparam int DEFAULT_SAMPLE_DEPTH = 4096;

	// Largest phase difference that still counts as a forward step.
	localparam logic [PHASE_W-1:0] PHASE_HALF_MAX = {1'b0, {(PHASE_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_INC    = 2'd0,
		REG_LOOP_START   = 2'd1,
		REG_LOOP_END     = 2'd2,
		REG_SAMPLE_COUNT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_RENDER = 1'b1
	} op_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD2  = 8'b0000_0010,
		ST_INT  = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_CHK  = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_FIX  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

endpackage

FILE: src/sample_player_interp_loop_unit.sv
// Sample player: sample store, 16.16 phase, linear interpolation, loop fold, gain and mix.
// Load item: written to the store at acceptance.
// Render item: the two reads of the one-port store, then two registered multiplies; a loop
// fold adds the check and fix steps, plus the bit-serial remainder unit when it needs it.
// One item is in work at a time. Reset clears phase, the state and the configuration
// registers, sets running; store contents are undefined until loaded.
`include "sample_player_interp_loop_unit_defines.svh"

module sample_player_interp_loop_unit #(
	parameter int SAMPLE_DEPTH = spil_pkg::DEFAULT_SAMPLE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wen,
	input  logic [spil_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spil_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [15:0]                          sample_addr,
	input  logic signed [spil_pkg::SAMPLE_W-1:0] sample_value,
	input  logic signed [spil_pkg::AMP_W-1:0]    amplitude,
	input  logic signed [spil_pkg::ACC_W-1:0]    acc_in,
	input  logic                                 block_end,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [spil_pkg::ACC_W-1:0]    acc_out,
	output logic                                 is_running,
	output logic                                 last_out
);
	import spil_pkg::*;

	localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(SAMPLE_DEPTH);

	// configuration registers and values derived from them
	logic [PHASE_W-1:0] inc_q, start_q, end_q;
	logic [COUNT_W-1:0] count_q;
	logic [PHASE_W-1:0] span_q, div_q, base_hi_q;
	logic               mode_q, span_zero_q;
	logic [PHASE_W-1:0] span_d;

	// control and work registers
	state_t                     state_q;
	logic [PHASE_W-1:0]         phase_q, sum_q, d_q, num_q, rem_q;
	logic                       running_q, fold_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic signed [SAMPLE_W-1:0] s1_q, h_q;
	logic signed [AMP_W-1:0]    amp_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       last_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       out_valid_q, is_running_q, last_out_q;
	logic signed [ACC_W-1:0]    acc_out_q;

	// sample store
	logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [AW-1:0]       rd_addr;
	logic                mem_we;

	// combinational helpers
	logic [POS_W-1:0]           pos;
	logic [FRAC_BITS-1:0]       frac;
	logic [COUNT_W-1:0]         pos_ext, pos_nxt_ext;
	logic                       in_acc, out_acc, out_free;
	logic signed [SAMPLE_W-1:0] s2;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [2*SAMPLE_W+1:0] slope;
	logic [PHASE_W-1:0]         v;
	logic [PHASE_W:0]           rem_sh, trial;
	logic                       fold;

	assign pos         = phase_q[PHASE_W-1:FRAC_BITS];
	assign frac        = phase_q[FRAC_BITS-1:0];
	assign pos_ext     = {1'b0, pos};
	assign pos_nxt_ext = pos_ext + COUNT_W'(1);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign acc_out    = acc_out_q;
	assign is_running = is_running_q;
	assign last_out   = last_out_q;

	// configuration writes; sample count is clamped to the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			count_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PHASE_INC:    inc_q   <= cfg_data;
				REG_LOOP_START:   start_q <= cfg_data;
				REG_LOOP_END:     end_q   <= cfg_data;
				REG_SAMPLE_COUNT: count_q <= (cfg_data[COUNT_W-1:0] > DEPTH_CNT) ?
					DEPTH_CNT : cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// loop span, fold mode and divisor, refreshed every cycle
	assign span_d = end_q - start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q      <= '0;
			mode_q      <= 1'b0;
			span_zero_q <= 1'b1;
			base_hi_q   <= PHASE_HALF_MAX;
			div_q       <= '0;
		end else begin
			span_q      <= span_d;
			mode_q      <= span_d[PHASE_W-1] && (|span_d[PHASE_W-2:0]);
			span_zero_q <= (span_d == '0);
			base_hi_q   <= start_q + PHASE_HALF_MAX;
			div_q       <= mode_q ? (PHASE_W'(0) - span_q) : span_q;
		end
	end

	// store port: loads write at acceptance, reads at pos then pos + 1
	assign mem_we  = in_acc && (opcode == OP_LOAD) && ({1'b0, sample_addr} < DEPTH_CNT);
	assign rd_addr = (state_q == ST_RD2) ? (pos[AW-1:0] + AW'(1)) : pos[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[sample_addr[AW-1:0]] <= sample_value;
		end
		rdata_q <= mem[rd_addr];
	end

	// interpolation between the two samples, floor rounding by truncation
	assign s2    = (pos_nxt_ext < count_q) ? signed'(rdata_q) : '0;
	assign diff  = (SAMPLE_W+1)'(s2) - (SAMPLE_W+1)'(s1_q);
	assign slope = diff * signed'({1'b0, frac});
	assign v     = {s1_q, {FRAC_BITS{1'b0}}} + slope[PHASE_W-1:0];
	assign fold  = (end_q != '0) && !d_q[PHASE_W-1];

	// one restoring remainder step
	assign rem_sh = {rem_q, num_q[PHASE_W-1]};
	assign trial  = rem_sh - {1'b0, div_q};

	// render sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			running_q <= 1'b1;
			fold_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (opcode == OP_RENDER)) begin
						state_q <= ST_RD2;
					end
				end
				ST_RD2: begin
					if (pos_ext >= count_q) begin
						running_q <= 1'b0;
					end
					state_q <= ST_INT;
				end
				ST_INT: begin
					fold_q <= fold;
					if (fold) begin
						running_q <= 1'b1;
					end else if (pos_nxt_ext >= count_q) begin
						running_q <= 1'b0;
					end
					if (!fold) begin
						phase_q <= sum_q;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= fold_q ? ST_CHK : ST_DONE;
				end
				ST_CHK: begin
					cnt_q <= '0;
					if (span_zero_q || (num_q < div_q)) begin
						state_q <= ST_FIX;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					phase_q <= mode_q ? (base_hi_q - rem_q) : (start_q + rem_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the render in work
	always_ff @(posedge clk) begin
		if (in_acc) begin
			amp_q  <= amplitude;
			acc_q  <= acc_in;
			last_q <= block_end;
		end
		if (state_q == ST_RD2) begin
			s1_q  <= (pos_ext < count_q) ? signed'(rdata_q) : '0;
			sum_q <= phase_q + inc_q;
			d_q   <= phase_q + inc_q - end_q;
		end
		if (state_q == ST_INT) begin
			h_q   <= signed'(v[PHASE_W-1:FRAC_BITS]);
			num_q <= mode_q ? (PHASE_HALF_MAX - d_q) : d_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= amp_q * h_q;
		end
		if (state_q == ST_CHK) begin
			rem_q <= (span_zero_q || (num_q < div_q)) ? num_q : '0;
		end
		if (state_q == ST_DIV) begin
			num_q <= {num_q[PHASE_W-2:0], 1'b0};
			rem_q <= trial[PHASE_W] ? rem_sh[PHASE_W-1:0] : trial[PHASE_W-1:0];
		end
	end

	// output register: hold until taken, load on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			acc_out_q    <= acc_q + {{(ACC_W-SAMPLE_W){prod_q[PROD_W-1]}},
				prod_q[PROD_W-1:AMP_W]};
			is_running_q <= running_q;
			last_out_q   <= last_q;
		end
	end

	// checks
	`SPIL_ASSERT_IMP(a_div_rem_below_divisor, state_q == ST_DIV, rem_q < div_q,
		"remainder not below divisor during division")
	`SPIL_ASSERT_NXT(a_render_starts_read, in_acc && (opcode == OP_RENDER), state_q == ST_RD2,
		"accepted render did not start the second read")
	`SPIL_ASSERT_NXT(a_fold_sets_running, state_q == ST_FIX, running_q,
		"loop fold left running flag clear")

endmodule
